// ===== hdl/atsp_pkg.sv =====
// Shared types, constants and helper functions of the terminal stream parser.
package atsp_pkg;

   localparam int GRID_COLS_DEF      = 53;
   localparam int GRID_ROWS_DEF      = 20;
   localparam int PARAM_DEPTH_DEF    = 24;
   localparam int MAX_SGR_PARAMS_DEF = 16;
   localparam int QUEUE_DEPTH_DEF    = 4;

   localparam logic [7:0] CH_ESC    = 8'h1b;
   localparam logic [7:0] CH_LBRACK = 8'h5b;
   localparam logic [7:0] CH_SEMI   = 8'h3b;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] FIN_LO    = 8'h40;
   localparam logic [7:0] FIN_HI    = 8'h7e;
   localparam logic [7:0] FIN_CUP   = 8'h48;  // H
   localparam logic [7:0] FIN_HVP   = 8'h66;  // f
   localparam logic [7:0] FIN_ED    = 8'h4a;  // J
   localparam logic [7:0] FIN_SGR   = 8'h6d;  // m
   localparam logic [7:0] FIN_BL    = 8'h70;  // p

   localparam logic [15:0] NUM_MAX  = 16'hffff;
   localparam logic [3:0]  FG_RESET = 4'd7;
   localparam int          RSP_DATA_W = 48;

   // work items handed from the front end to the executor
   typedef enum logic [1:0] {
      OP_GLYPH = 2'd0,
      OP_START = 2'd1,
      OP_PARAM = 2'd2,
      OP_FINAL = 2'd3
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [15:0] data;
   } op_item_type;

   typedef struct packed {
      logic [3:0] fg;
      logic [3:0] bg;
      logic [3:0] attr;  // bit 0 bold, 1 dim, 2 underline, 3 inverse
   } sgr_state_type;

   typedef struct packed {
      logic        kind;
      logic [4:0]  cell_row;
      logic [5:0]  cell_col;
      logic [15:0] code_point;
      logic [3:0]  fg_index;
      logic [3:0]  bg_index;
      logic        dim;
      logic        underline;
      logic [7:0]  backlight_duty;
   } rsp_type;

   function automatic logic is_digit(input logic [7:0] ch);
      return (ch >= CH_ZERO) && (ch <= CH_NINE);
   endfunction

   // v * 10 + digit, saturating at 65535
   function automatic logic [15:0] add_digit(input logic [15:0] v, input logic [7:0] ch);
      logic [19:0] t;
      t = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {16'd0, ch[3:0]};
      return (t > {4'd0, NUM_MAX}) ? NUM_MAX : t[15:0];
   endfunction

   function automatic sgr_state_type sgr_apply(input logic [15:0] p, input sgr_state_type s);
      sgr_state_type r;
      r = s;
      if (p == 16'd0) begin
         r.fg = FG_RESET;
         r.bg = 4'd0;
         r.attr = 4'd0;
      end else if (p == 16'd1) begin
         r.attr[0] = 1'b1;
      end else if (p == 16'd2) begin
         r.attr[1] = 1'b1;
      end else if (p == 16'd4) begin
         r.attr[2] = 1'b1;
      end else if (p == 16'd7) begin
         r.attr[3] = 1'b1;
      end else if (p >= 16'd30 && p <= 16'd37) begin
         r.fg = 4'(p - 16'd30);
      end else if (p >= 16'd90 && p <= 16'd97) begin
         r.fg = 4'(p - 16'd82);
      end else if (p >= 16'd40 && p <= 16'd47) begin
         r.bg = 4'(p - 16'd40);
      end else if (p >= 16'd100 && p <= 16'd107) begin
         r.bg = 4'(p - 16'd92);
      end
      return r;
   endfunction

endpackage

// ===== hdl/ansi_terminal_stream_parser.sv =====
// Top level of the ANSI terminal stream parser: classifier, queue and executor.
//
//   channel   dir   handshake              payload
//   req_      in    req_tvalid/req_tready  req_tdata[7:0] = rx_byte
//   rsp_      out   rsp_tvalid/rsp_tready  rsp_tuser = kind, rsp_tdata = cell/duty fields
//
// The classifier takes one word per cycle while the queue has room. The
// executor handles a glyph or a parameter byte from its idle state, and for
// the CSI final bytes H, f, m and p walks the parameter buffer one entry a
// cycle through its registered read port, then applies the result in a
// finish state; at most PARAM_DEPTH parameter bytes are stored.
// Reset is synchronous and clears the parse mode, cursor and attributes; the
// parameter buffer holds no reset value. A stalled result holds the executor,
// the queue then fills and req_tready drops.
module ansi_terminal_stream_parser
   import atsp_pkg::*;
#(
   parameter int GRID_COLS      = GRID_COLS_DEF,
   parameter int GRID_ROWS      = GRID_ROWS_DEF,
   parameter int PARAM_DEPTH    = PARAM_DEPTH_DEF,
   parameter int MAX_SGR_PARAMS = MAX_SGR_PARAMS_DEF,
   parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] rx_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic                  rsp_tuser,   // [0] kind
   // [4:0] cell_row, [10:5] cell_col, [26:11] code_point, [30:27] fg_index,
   // [34:31] bg_index, [35] dim, [36] underline, [44:37] backlight_duty, rest zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic        q_full, push, head_valid, pop;
   op_item_type push_item, head_item;
   rsp_type     rsp_data;

   atsp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .push       (push),
      .push_item  (push_item)
   );

   atsp_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (q_full),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop)
   );

   atsp_exec #(
      .GRID_COLS      (GRID_COLS),
      .GRID_ROWS      (GRID_ROWS),
      .PARAM_DEPTH    (PARAM_DEPTH),
      .MAX_SGR_PARAMS (MAX_SGR_PARAMS)
   ) u_exec (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data)
   );

   // pack result fields, lowest field first
   assign rsp_tuser = rsp_data.kind;
   assign rsp_tdata = {3'b000,
                       rsp_data.backlight_duty,
                       rsp_data.underline,
                       rsp_data.dim,
                       rsp_data.bg_index,
                       rsp_data.fg_index,
                       rsp_data.code_point,
                       rsp_data.cell_col,
                       rsp_data.cell_row};

endmodule

// ===== hdl/atsp_front.sv =====
// Byte classifier: escape mode tracking and UTF-8 assembly into work items.
module atsp_front
   import atsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        q_full,
   output logic        push,
   output op_item_type push_item
);

   typedef enum logic [2:0] {
      MODE_TEXT = 3'b001,
      MODE_ESC  = 3'b010,
      MODE_CSI  = 3'b100
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [15:0] acc_ff, acc_in;
   logic [1:0]  rem_ff, rem_in;
   logic        take;
   logic [15:0] acc_next;

   assign req_tready = !q_full;
   assign take       = req_tvalid && req_tready;
   assign acc_next   = {acc_ff[9:0], req_tdata[5:0]};

   always_comb begin
      mode_in   = mode_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      push      = 1'b0;
      push_item = '{op: OP_GLYPH, data: {8'd0, req_tdata}};
      if (take) begin
         unique case (mode_ff)
            MODE_ESC: begin
               if (req_tdata == CH_LBRACK) begin
                  mode_in = MODE_CSI;
                  push = 1'b1;
                  push_item.op = OP_START;
               end else begin
                  mode_in = MODE_TEXT;
               end
            end
            MODE_CSI: begin
               push = 1'b1;
               if (req_tdata >= FIN_LO && req_tdata <= FIN_HI) begin
                  mode_in = MODE_TEXT;
                  push_item.op = OP_FINAL;
               end else begin
                  push_item.op = OP_PARAM;
               end
            end
            default: begin
               if (req_tdata == CH_ESC) begin
                  mode_in = MODE_ESC;
               end else if (rem_ff != 2'd0) begin
                  acc_in = acc_next;
                  rem_in = rem_ff - 2'd1;
                  if (rem_ff == 2'd1) begin
                     push = 1'b1;
                     push_item.data = acc_next;
                  end
               end else if (!req_tdata[7]) begin
                  push = (req_tdata >= CH_SPACE);
               end else if (req_tdata[7:5] == 3'b110) begin
                  acc_in = {11'd0, req_tdata[4:0]};
                  rem_in = 2'd1;
               end else if (req_tdata[7:4] == 4'b1110) begin
                  acc_in = {12'd0, req_tdata[3:0]};
                  rem_in = 2'd2;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_TEXT;
         acc_ff  <= 16'd0;
         rem_ff  <= 2'd0;
      end else begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         rem_ff  <= rem_in;
      end
   end

endmodule

// ===== hdl/atsp_queue.sv =====
// Small work-item queue between the classifier and the executor.
module atsp_queue
   import atsp_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  op_item_type push_item,
   output logic        full,
   output logic        head_valid,
   output op_item_type head_item,
   input  logic        pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   op_item_type       slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              do_pop;

   assign full       = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_item  = slots_ff[rd_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== hdl/atsp_exec.sv =====
// Executor: cursor and attribute state, parameter buffer walk, result register.
module atsp_exec
   import atsp_pkg::*;
#(
   parameter int GRID_COLS      = GRID_COLS_DEF,
   parameter int GRID_ROWS      = GRID_ROWS_DEF,
   parameter int PARAM_DEPTH    = PARAM_DEPTH_DEF,
   parameter int MAX_SGR_PARAMS = MAX_SGR_PARAMS_DEF
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  op_item_type head_item,
   output logic        pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output rsp_type     rsp_data
);

   localparam int ADDR_W = $clog2(PARAM_DEPTH);
   localparam int CNT_W  = $clog2(PARAM_DEPTH + 1);
   localparam int USED_W = $clog2(MAX_SGR_PARAMS + 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_WALK   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [7:0]       pbuf [PARAM_DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             rvalid_ff, rvalid_in;
   logic [7:0]       rdata_ff;
   logic [7:0]       fin_ff, fin_in;
   logic [15:0]      acc_a_ff, acc_a_in, acc_b_ff, acc_b_in;
   logic [1:0]       field_ff, field_in;
   logic             any_ff, any_in;
   logic [USED_W-1:0] used_ff, used_in;
   logic [15:0]      row_ff, row_in, col_ff, col_in;
   sgr_state_type    sgr_ff, sgr_in;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_ff, out_in;
   logic             out_free, pbuf_wr;
   logic [3:0]       fg_eff, bg_eff;
   logic             off_grid;
   logic [15:0]      col_step;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_data   = out_ff;
   assign off_grid   = (row_ff >= 16'(GRID_ROWS)) || (col_ff >= 16'(GRID_COLS));
   assign col_step   = (col_ff == NUM_MAX) ? col_ff : col_ff + 16'd1;
   assign pbuf_wr    = (state_ff == ST_IDLE) && head_valid &&
                       (head_item.op == OP_PARAM) && (count_ff < CNT_W'(PARAM_DEPTH));

   always_comb begin
      fg_eff = sgr_ff.attr[0] ? (sgr_ff.fg | 4'd8) : sgr_ff.fg;
      bg_eff = sgr_ff.bg;
      if (sgr_ff.attr[3]) begin
         fg_eff = sgr_ff.bg;
         bg_eff = sgr_ff.attr[0] ? (sgr_ff.fg | 4'd8) : sgr_ff.fg;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rvalid_in    = 1'b0;
      fin_in       = fin_ff;
      acc_a_in     = acc_a_ff;
      acc_b_in     = acc_b_ff;
      field_in     = field_ff;
      any_in       = any_ff;
      used_in      = used_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      sgr_in       = sgr_ff;
      pop          = 1'b0;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_in       = out_ff;

      unique case (state_ff)
         ST_WALK: begin
            if (idx_ff < count_ff) begin
               idx_in    = idx_ff + CNT_W'(1);
               rvalid_in = 1'b1;
            end else if (!rvalid_ff) begin
               state_in = ST_FINISH;
            end
            if (rvalid_ff) begin
               if (fin_ff == FIN_SGR) begin
                  if (rdata_ff == CH_SEMI) begin
                     if (used_ff < USED_W'(MAX_SGR_PARAMS)) begin
                        sgr_in  = sgr_apply(acc_a_ff, sgr_ff);
                        used_in = used_ff + USED_W'(1);
                     end
                     acc_a_in = 16'd0;
                  end else if (is_digit(rdata_ff)) begin
                     acc_a_in = add_digit(acc_a_ff, rdata_ff);
                  end
               end else if (fin_ff == FIN_BL) begin
                  if (is_digit(rdata_ff)) begin
                     acc_a_in = add_digit(acc_a_ff, rdata_ff);
                     any_in   = 1'b1;
                  end
               end else begin
                  // cursor position: row then column, later fields ignored
                  if (rdata_ff == CH_SEMI) begin
                     field_in = (field_ff == 2'd2) ? field_ff : field_ff + 2'd1;
                  end else if (is_digit(rdata_ff)) begin
                     if (field_ff == 2'd0) begin
                        acc_a_in = add_digit(acc_a_ff, rdata_ff);
                     end else if (field_ff == 2'd1) begin
                        acc_b_in = add_digit(acc_b_ff, rdata_ff);
                     end
                  end
               end
            end
         end
         ST_FINISH: begin
            if (fin_ff == FIN_SGR) begin
               if (used_ff < USED_W'(MAX_SGR_PARAMS)) begin
                  sgr_in = sgr_apply(acc_a_ff, sgr_ff);
               end
               state_in = ST_IDLE;
            end else if (fin_ff == FIN_BL) begin
               if (!any_ff) begin
                  state_in = ST_IDLE;
               end else if (out_free) begin
                  out_valid_in = 1'b1;
                  out_in = '0;
                  out_in.kind = 1'b1;
                  out_in.backlight_duty = (acc_a_ff > 16'd255) ? 8'hff : acc_a_ff[7:0];
                  state_in = ST_IDLE;
               end
            end else begin
               row_in   = (acc_a_ff != 16'd0) ? acc_a_ff - 16'd1 : 16'd0;
               col_in   = (acc_b_ff != 16'd0) ? acc_b_ff - 16'd1 : 16'd0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            if (head_valid) begin
               unique case (head_item.op)
                  OP_GLYPH: begin
                     if (off_grid) begin
                        col_in = col_step;
                        pop    = 1'b1;
                     end else if (out_free) begin
                        out_valid_in       = 1'b1;
                        out_in             = '0;
                        out_in.cell_row    = row_ff[4:0];
                        out_in.cell_col    = col_ff[5:0];
                        out_in.code_point  = head_item.data;
                        out_in.fg_index    = fg_eff;
                        out_in.bg_index    = bg_eff;
                        out_in.dim         = sgr_ff.attr[1];
                        out_in.underline   = sgr_ff.attr[2];
                        col_in             = col_step;
                        pop                = 1'b1;
                     end
                  end
                  OP_START: begin
                     count_in = '0;
                     pop      = 1'b1;
                  end
                  OP_PARAM: begin
                     if (pbuf_wr) begin
                        count_in = count_ff + CNT_W'(1);
                     end
                     pop = 1'b1;
                  end
                  default: begin
                     pop      = 1'b1;
                     fin_in   = head_item.data[7:0];
                     acc_a_in = 16'd0;
                     acc_b_in = 16'd0;
                     field_in = 2'd0;
                     any_in   = 1'b0;
                     used_in  = '0;
                     idx_in   = '0;
                     if (head_item.data[7:0] == FIN_ED) begin
                        row_in = 16'd0;
                        col_in = 16'd0;
                     end else if (head_item.data[7:0] == FIN_CUP ||
                                  head_item.data[7:0] == FIN_HVP ||
                                  head_item.data[7:0] == FIN_SGR ||
                                  head_item.data[7:0] == FIN_BL) begin
                        state_in = ST_WALK;
                     end
                  end
               endcase
            end
         end
      endcase
   end

   // parameter buffer: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (pbuf_wr) begin
         pbuf[count_ff[ADDR_W-1:0]] <= head_item.data[7:0];
      end
      rdata_ff <= pbuf[idx_ff[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      fin_ff   <= fin_in;
      acc_a_ff <= acc_a_in;
      acc_b_ff <= acc_b_in;
      field_ff <= field_in;
      any_ff   <= any_in;
      used_ff  <= used_in;
      idx_ff   <= idx_in;
      out_ff   <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rvalid_ff    <= 1'b0;
         row_ff       <= 16'd0;
         col_ff       <= 16'd0;
         sgr_ff       <= '{fg: FG_RESET, bg: 4'd0, attr: 4'd0};
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rvalid_ff    <= rvalid_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         sgr_ff       <= sgr_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule
